@@ sv/tvsg_pkg.sv @@
package tvsg_pkg;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    localparam logic [3:0] REG_NOISE   = 4'd6;
    localparam logic [3:0] REG_MIXER   = 4'd7;
    localparam logic [3:0] REG_LEVEL_A = 4'd8;
    localparam logic [3:0] REG_ENV_LO  = 4'd11;
    localparam logic [3:0] REG_ENV_HI  = 4'd12;
    localparam logic [3:0] REG_SHAPE   = 4'd13;
    localparam logic [3:0] REG_PORT_A  = 4'd14;
    localparam logic [3:0] REG_PORT_B  = 4'd15;

    localparam logic [16:0] LFSR_TAPS       = 17'h12000;
    localparam logic [11:0] SHORT_TONE      = 12'd5;
    localparam logic [7:0]  READ_OUT_OF_MAP = 8'hff;

    localparam logic [1:0] ENV_SEG_RISE  = 2'd0;
    localparam logic [1:0] ENV_SEG_FALL  = 2'd1;
    localparam logic [1:0] ENV_SEG_START = 2'd2;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] inc;
    } env_entry_t;

    // start value and per-substep increment of one envelope segment
    function automatic env_entry_t env_lookup(input logic [3:0] shape, input logic [1:0] seg);
        logic [47:0] row;
        env_entry_t  e;
        case (shape)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd9:   row = 48'hffff_0000_0000;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd15:  row = 48'h0001_0000_0000;
            4'd8:                           row = 48'hffff_ffff_ffff;
            4'd10:                          row = 48'hffff_ffff_0001;
            4'd11:                          row = 48'hffff_ff00_ff00;
            4'd12:                          row = 48'h0001_0001_0001;
            4'd13:                          row = 48'h0001_ff00_ff00;
            4'd14:                          row = 48'h0001_0001_ffff;
            default:                        row = '0;
        endcase
        case (seg)
            ENV_SEG_RISE: e = row[15:0];
            ENV_SEG_FALL: e = row[31:16];
            default:      e = row[47:32];
        endcase
        return e;
    endfunction

endpackage

@@ sv/three_voice_sound_generator.sv @@
// channel | dir | beat payload
// s       | in  | tuser: operation[1:0]; tdata: data_value[7:0]
// m       | out | tdata: read_data, level_a/b/c, port_a_value, port_a_changed,
//         |     |        port_b_value, port_b_changed (zero pad to 40 bits)
//
// One beat per cycle unless stalled; each input beat yields one output beat next cycle.
// All state updates happen in the cycle of the input beat, in one combinational pass.
// Levels and port bytes on m_tdata are derived from the live state registers.
// A single output register decouples the sides: s_tready drops only while it
// is full and m_tready is low.
// rst_n clears the register file and resets all generator state.
module three_voice_sound_generator #(
    parameter int ENVELOPE_STEPS = 32,
    parameter int VOICES         = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_value[7:0]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], level_a[11:8], level_b[15:12], level_c[19:16],
    // port_a_value[27:20], port_a_changed[28], port_b_value[36:29],
    // port_b_changed[37], zero[39:38]
    output logic [39:0] m_tdata
);

    localparam int SUB_W = $clog2(ENVELOPE_STEPS + 1);
    localparam logic [SUB_W-1:0] SUB_RELOAD = SUB_W'(ENVELOPE_STEPS);

    logic [7:0]       reg_file_reg [16];
    logic [7:0]       reg_file_next [16];
    logic [7:0]       sel_reg, sel_next;
    logic [11:0]      tone_ctr_reg [VOICES];
    logic [11:0]      tone_ctr_next [VOICES];
    logic             tone_phase_reg [VOICES];
    logic             tone_phase_next [VOICES];
    logic [11:0]      tone_period [VOICES];
    logic [4:0]       noise_ctr_reg, noise_ctr_next;
    logic [16:0]      lfsr_reg, lfsr_next;
    logic [15:0]      env_cnt_reg, env_cnt_next;
    logic [SUB_W-1:0] env_sub_reg, env_sub_next;
    logic [7:0]       env_value_reg, env_value_next;
    logic [7:0]       env_inc_reg, env_inc_next;
    logic             env_parity_reg, env_parity_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       rd_reg, rd_next;
    logic             pa_reg, pa_next;
    logic             pb_reg, pb_next;

    logic [4:0]  noise_period;
    logic [15:0] env_period;
    logic [15:0] env_period_raw;
    logic [3:0]  level [3];
    logic        accept;
    tvsg_pkg::op_t      op;
    tvsg_pkg::env_entry_t env_e;
    logic [SUB_W-1:0]   sub_dec;
    logic [4:0]         noise_dec;
    logic [15:0]        env_dec;
    logic [11:0]        tone_dec;

    assign op       = tvsg_pkg::op_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign noise_period = (reg_file_reg[tvsg_pkg::REG_NOISE][4:0] == 5'd0) ? 5'd1
                        : reg_file_reg[tvsg_pkg::REG_NOISE][4:0];
    assign env_period   = ({reg_file_reg[tvsg_pkg::REG_ENV_HI],
                            reg_file_reg[tvsg_pkg::REG_ENV_LO]} == 16'd0) ? 16'd1
                        : {reg_file_reg[tvsg_pkg::REG_ENV_HI],
                           reg_file_reg[tvsg_pkg::REG_ENV_LO]};

    genvar gv;
    generate
        for (gv = 0; gv < VOICES; gv++)
        begin : g_period
            logic [11:0] raw;
            assign raw = {reg_file_reg[4'(2*gv+1)][3:0], reg_file_reg[4'(2*gv)]};
            assign tone_period[gv] = (raw == 12'd0) ? 12'd1 : raw;
        end
    endgenerate

    always_comb
    begin
        reg_file_next   = reg_file_reg;
        sel_next        = sel_reg;
        tone_ctr_next   = tone_ctr_reg;
        tone_phase_next = tone_phase_reg;
        noise_ctr_next  = noise_ctr_reg;
        lfsr_next       = lfsr_reg;
        env_cnt_next    = env_cnt_reg;
        env_sub_next    = env_sub_reg;
        env_value_next  = env_value_reg;
        env_inc_next    = env_inc_reg;
        env_parity_next = env_parity_reg;
        out_valid_next  = out_valid_reg;
        rd_next         = rd_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        env_e           = '0;
        env_period_raw  = '0;
        sub_dec         = '0;
        noise_dec       = '0;
        env_dec         = '0;
        tone_dec        = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
            rd_next        = '0;
            pa_next        = 1'b0;
            pb_next        = 1'b0;
            case (op)
                tvsg_pkg::OP_SELECT:
                begin
                    sel_next = s_tdata;
                end
                tvsg_pkg::OP_WRITE:
                begin
                    if (sel_reg[7:4] == 4'd0)
                    begin
                        reg_file_next[sel_reg[3:0]] = s_tdata;
                        case (sel_reg[3:0])
                            tvsg_pkg::REG_ENV_LO, tvsg_pkg::REG_ENV_HI:
                            begin
                                env_period_raw = (sel_reg[3:0] == tvsg_pkg::REG_ENV_LO)
                                    ? {reg_file_reg[tvsg_pkg::REG_ENV_HI], s_tdata}
                                    : {s_tdata, reg_file_reg[tvsg_pkg::REG_ENV_LO]};
                                env_cnt_next = (env_period_raw == 16'd0) ? 16'd1
                                             : env_period_raw;
                            end
                            tvsg_pkg::REG_SHAPE:
                            begin
                                env_e           = tvsg_pkg::env_lookup(s_tdata[3:0],
                                                      tvsg_pkg::ENV_SEG_START);
                                env_value_next  = env_e.value;
                                env_inc_next    = env_e.inc;
                                env_parity_next = 1'b1;
                                env_cnt_next    = env_period;
                                env_sub_next    = SUB_RELOAD;
                            end
                            tvsg_pkg::REG_PORT_A:
                            begin
                                pa_next = (reg_file_reg[tvsg_pkg::REG_PORT_A] != s_tdata);
                            end
                            tvsg_pkg::REG_PORT_B:
                            begin
                                pb_next = (reg_file_reg[tvsg_pkg::REG_PORT_B] != s_tdata);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                tvsg_pkg::OP_READ:
                begin
                    rd_next = (sel_reg[7:4] != 4'd0) ? tvsg_pkg::READ_OUT_OF_MAP
                            : reg_file_reg[sel_reg[3:0]];
                end
                default:
                begin
                    noise_dec = noise_ctr_reg - 5'd1;
                    if (noise_dec == 5'd0)
                    begin
                        noise_ctr_next = noise_period;
                        lfsr_next      = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ tvsg_pkg::LFSR_TAPS)
                                       : (lfsr_reg >> 1);
                    end
                    else
                    begin
                        noise_ctr_next = noise_dec;
                    end

                    for (int v = 0; v < VOICES; v++)
                    begin
                        tone_dec = tone_ctr_reg[v] - 12'd1;
                        if (tone_dec == 12'd0)
                        begin
                            tone_ctr_next[v]   = tone_period[v];
                            tone_phase_next[v] = !tone_phase_reg[v];
                        end
                        else
                        begin
                            tone_ctr_next[v] = tone_dec;
                        end
                        if (tone_period[v] < tvsg_pkg::SHORT_TONE)
                        begin
                            tone_phase_next[v] = 1'b1;
                        end
                    end

                    env_dec = env_cnt_reg - 16'd1;
                    if (env_dec == 16'd0)
                    begin
                        env_cnt_next = env_period;
                        sub_dec      = env_sub_reg - SUB_W'(1);
                        if (sub_dec == '0)
                        begin
                            env_sub_next    = SUB_RELOAD;
                            env_parity_next = !env_parity_reg;
                            env_e           = tvsg_pkg::env_lookup(
                                                  reg_file_reg[tvsg_pkg::REG_SHAPE][3:0],
                                                  {1'b0, !env_parity_reg});
                            env_value_next  = env_e.value;
                            env_inc_next    = env_e.inc;
                        end
                        else
                        begin
                            env_sub_next   = sub_dec;
                            env_value_next = env_value_reg + env_inc_reg;
                        end
                    end
                    else
                    begin
                        env_cnt_next = env_dec;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 16; r++)
            begin
                reg_file_reg[r] <= '0;
            end
            for (int v = 0; v < VOICES; v++)
            begin
                tone_ctr_reg[v]   <= 12'd1;
                tone_phase_reg[v] <= 1'b0;
            end
            sel_reg        <= '0;
            noise_ctr_reg  <= 5'd1;
            lfsr_reg       <= 17'd1;
            env_cnt_reg    <= 16'd1;
            env_sub_reg    <= SUB_RELOAD;
            env_value_reg  <= '0;
            env_inc_reg    <= '0;
            env_parity_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_reg         <= '0;
            pa_reg         <= 1'b0;
            pb_reg         <= 1'b0;
        end
        else
        begin
            reg_file_reg   <= reg_file_next;
            tone_ctr_reg   <= tone_ctr_next;
            tone_phase_reg <= tone_phase_next;
            sel_reg        <= sel_next;
            noise_ctr_reg  <= noise_ctr_next;
            lfsr_reg       <= lfsr_next;
            env_cnt_reg    <= env_cnt_next;
            env_sub_reg    <= env_sub_next;
            env_value_reg  <= env_value_next;
            env_inc_reg    <= env_inc_next;
            env_parity_reg <= env_parity_next;
            out_valid_reg  <= out_valid_next;
            rd_reg         <= rd_next;
            pa_reg         <= pa_next;
            pb_reg         <= pb_next;
        end
    end

    // mixer
    genvar gc;
    generate
        for (gc = 0; gc < 3; gc++)
        begin : g_level
            if (gc < VOICES)
            begin : g_on
                logic       tdis;
                logic       ndis;
                logic       on;
                logic [7:0] lreg;
                logic [3:0] raw;
                assign tdis = reg_file_reg[tvsg_pkg::REG_MIXER][gc];
                assign ndis = reg_file_reg[tvsg_pkg::REG_MIXER][3+gc];
                assign on   = (tdis || tone_phase_reg[gc]) && (ndis || lfsr_reg[0]);
                assign lreg = reg_file_reg[tvsg_pkg::REG_LEVEL_A + 4'(gc)];
                assign raw  = lreg[4] ? env_value_reg[4:1] : lreg[3:0];
                assign level[gc] = !on ? 4'd0
                                 : (raw != 4'd0 && !tdis &&
                                    tone_period[gc] < tvsg_pkg::SHORT_TONE) ? raw - 4'd1
                                 : raw;
            end
            else
            begin : g_off
                assign level[gc] = 4'd0;
            end
        end
    endgenerate

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, pb_reg, reg_file_reg[tvsg_pkg::REG_PORT_B],
                       pa_reg, reg_file_reg[tvsg_pkg::REG_PORT_A],
                       level[2], level[1], level[0], rd_reg};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_flags_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op != tvsg_pkg::OP_WRITE |=> !pa_reg && !pb_reg)
        else $error("port change flag without a write");

    a_read_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op != tvsg_pkg::OP_READ |=> rd_reg == 8'd0)
        else $error("read data set without a read");

    a_substep_range: assert property (@(posedge clk) disable iff (!rst_n)
        env_sub_reg != '0 && env_sub_reg <= SUB_RELOAD)
        else $error("envelope substep out of range");

    a_lfsr_alive: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != 17'd0)
        else $error("noise LFSR locked at zero");

endmodule

@@ sim/three_voice_sound_generator_tb.sv @@
`timescale 1ns / 100ps

module three_voice_sound_generator_tb;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int TOTAL_BEATS  = 1450;
    localparam int DRAIN_CYCLES = 8;
    localparam int ENV_STEPS    = 32;
    localparam int VOICE_COUNT  = 3;
    localparam int REG_COUNT    = 16;
    localparam int TONE_REGS    = 6;

    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_LEVEL_B   = tvsg_pkg::REG_LEVEL_A + 4'd1;

    typedef struct packed {
        logic [1:0] pad;
        logic       port_b_changed;
        logic [7:0] port_b_value;
        logic       port_a_changed;
        logic [7:0] port_a_value;
        logic [3:0] level_c;
        logic [3:0] level_b;
        logic [3:0] level_a;
        logic [7:0] read_data;
    } result_beat_t;

    typedef struct packed {
        tvsg_pkg::op_t op;
        logic [7:0]    value;
        logic          typed;
        logic [7:0]    typed_read;
    } script_row_t;

    localparam int SCRIPT_LEN = 26;
    localparam script_row_t OPENING_SCRIPT [SCRIPT_LEN] = '{
        '{tvsg_pkg::OP_READ,   8'h00,                          1'b1, 8'h00},
        '{tvsg_pkg::OP_SELECT, 8'hff,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_READ,   8'h00,                          1'b1, 8'hff},
        '{tvsg_pkg::OP_WRITE,  8'haa,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_SELECT, 8'h10,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_READ,   8'h00,                          1'b1, 8'hff},
        '{tvsg_pkg::OP_SELECT, {4'd0, tvsg_pkg::REG_PORT_A},   1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'hff,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'hff,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_READ,   8'h00,                          1'b1, 8'hff},
        '{tvsg_pkg::OP_SELECT, {4'd0, tvsg_pkg::REG_PORT_B},   1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h00,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h80,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_SELECT, {4'd0, REG_TONE_A_LO},          1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h00,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_SELECT, {4'd0, tvsg_pkg::REG_LEVEL_A},  1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h0f,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_SELECT, {4'd0, REG_LEVEL_B},            1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h1f,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_TICK,   8'h00,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_SELECT, {4'd0, tvsg_pkg::REG_SHAPE},    1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h0e,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_TICK,   8'hff,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_SELECT, {4'd0, tvsg_pkg::REG_NOISE},    1'b0, 8'h00},
        '{tvsg_pkg::OP_WRITE,  8'h00,                          1'b0, 8'h00},
        '{tvsg_pkg::OP_READ,   8'h00,                          1'b1, 8'h00}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    three_voice_sound_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted chip state
    logic [7:0]  chip_regs [REG_COUNT];
    logic [7:0]  selected;
    logic [11:0] tone_len [VOICE_COUNT];
    logic [11:0] tone_ctr [VOICE_COUNT];
    logic        tone_hi [VOICE_COUNT];
    logic [4:0]  noise_len;
    logic [4:0]  noise_ctr;
    logic [16:0] lfsr;
    logic [15:0] env_per;
    logic [15:0] env_cnt;
    logic [5:0]  env_sub;
    logic [7:0]  env_level;
    logic [7:0]  env_inc;
    logic [7:0]  env_step;

    result_beat_t expected_beats [$];
    bit           steady = 1'b0;
    int           cycles = 0;
    int           beats_sent = 0;
    int           ticks_sent = 0;
    int           writes_sent = 0;
    int           reads_sent = 0;
    int           results_checked = 0;
    int           mismatches = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // start value and per-substep step of one envelope segment
    function automatic logic [15:0] shape_segment(logic [3:0] shape, logic [1:0] seg);
        logic [2:0][15:0] row;
        case (shape)
            4'd8:                          row = {16'hffff, 16'hffff, 16'hffff};
            4'd10:                         row = {16'hffff, 16'hffff, 16'h0001};
            4'd11:                         row = {16'hffff, 16'hff00, 16'hff00};
            4'd12:                         row = {16'h0001, 16'h0001, 16'h0001};
            4'd13:                         row = {16'h0001, 16'hff00, 16'hff00};
            4'd14:                         row = {16'h0001, 16'h0001, 16'hffff};
            4'd4, 4'd5, 4'd6, 4'd7, 4'd15: row = {16'h0001, 16'h0000, 16'h0000};
            default:                       row = {16'hffff, 16'h0000, 16'h0000};
        endcase
        return row[seg];
    endfunction

    function automatic result_beat_t sound_after_beat(tvsg_pkg::op_t op, logic [7:0] val);
        result_beat_t r;
        logic [3:0]   idx;
        logic [15:0]  seg;
        logic [11:0]  per;
        logic [7:0]   lo;
        logic [7:0]   hi;
        logic [7:0]   lv;
        logic [7:0]   mix;
        logic [3:0]   lvls [VOICE_COUNT];
        int           v;
        r = '0;
        idx = selected[3:0];
        case (op)
            tvsg_pkg::OP_SELECT: selected = val;
            tvsg_pkg::OP_WRITE:
            begin
                if (selected < REG_COUNT && idx < TONE_REGS)
                begin
                    v = idx >> 1;
                    lo = idx[0] ? chip_regs[2 * v] : val;
                    hi = idx[0] ? val : chip_regs[2 * v + 1];
                    if (lo != chip_regs[2 * v] || hi != chip_regs[2 * v + 1])
                    begin
                        chip_regs[2 * v] = lo;
                        chip_regs[2 * v + 1] = hi;
                        per = {hi[3:0], lo};
                        tone_len[v] = (per == 12'd0) ? 12'd1 : per;
                    end
                end
                else if (selected < REG_COUNT)
                begin
                    case (idx)
                        tvsg_pkg::REG_NOISE:
                        begin
                            chip_regs[idx] = val;
                            noise_len = (val[4:0] == 5'd0) ? 5'd1 : val[4:0];
                        end
                        tvsg_pkg::REG_ENV_LO, tvsg_pkg::REG_ENV_HI:
                        begin
                            chip_regs[idx] = val;
                            env_per = {chip_regs[tvsg_pkg::REG_ENV_HI],
                                       chip_regs[tvsg_pkg::REG_ENV_LO]};
                            if (env_per == 16'd0)
                                env_per = 16'd1;
                            env_cnt = env_per;
                        end
                        tvsg_pkg::REG_SHAPE:
                        begin
                            seg = shape_segment(val[3:0], tvsg_pkg::ENV_SEG_START);
                            env_level = seg[15:8];
                            env_inc = seg[7:0];
                            env_step = 8'd1;
                            env_cnt = env_per;
                            env_sub = 6'(ENV_STEPS);
                            chip_regs[idx] = val;
                        end
                        tvsg_pkg::REG_PORT_A:
                        begin
                            r.port_a_changed = (chip_regs[idx] != val);
                            chip_regs[idx] = val;
                        end
                        tvsg_pkg::REG_PORT_B:
                        begin
                            r.port_b_changed = (chip_regs[idx] != val);
                            chip_regs[idx] = val;
                        end
                        default: chip_regs[idx] = val;
                    endcase
                end
            end
            tvsg_pkg::OP_READ:
                r.read_data = (selected >= REG_COUNT) ? tvsg_pkg::READ_OUT_OF_MAP
                                                      : chip_regs[idx];
            default:
            begin
                noise_ctr = noise_ctr - 5'd1;
                if (noise_ctr == 5'd0)
                begin
                    noise_ctr = noise_len;
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ tvsg_pkg::LFSR_TAPS) : (lfsr >> 1);
                end
                for (v = 0; v < VOICE_COUNT; v++)
                begin
                    tone_ctr[v] = tone_ctr[v] - 12'd1;
                    if (tone_ctr[v] == 12'd0)
                    begin
                        tone_ctr[v] = tone_len[v];
                        tone_hi[v] = ~tone_hi[v];
                    end
                    if (tone_len[v] < tvsg_pkg::SHORT_TONE)
                        tone_hi[v] = 1'b1;
                end
                env_cnt = env_cnt - 16'd1;
                if (env_cnt == 16'd0)
                begin
                    env_cnt = env_per;
                    env_sub = env_sub - 6'd1;
                    if (env_sub == 6'd0)
                    begin
                        env_sub = 6'(ENV_STEPS);
                        env_step = env_step + 8'd1;
                        seg = shape_segment(chip_regs[tvsg_pkg::REG_SHAPE][3:0],
                                            env_step[0] ? tvsg_pkg::ENV_SEG_FALL
                                                        : tvsg_pkg::ENV_SEG_RISE);
                        env_level = seg[15:8];
                        env_inc = seg[7:0];
                    end
                    else
                        env_level = env_level + env_inc;
                end
            end
        endcase

        mix = chip_regs[tvsg_pkg::REG_MIXER];
        for (v = 0; v < VOICE_COUNT; v++)
        begin
            lv = 8'd0;
            if ((mix[v] | tone_hi[v]) & (mix[3 + v] | lfsr[0]))
            begin
                lv = chip_regs[tvsg_pkg::REG_LEVEL_A + v][4]
                   ? {4'd0, env_level[4:1]}
                   : {4'd0, chip_regs[tvsg_pkg::REG_LEVEL_A + v][3:0]};
                if (lv != 8'd0 && !mix[v] && tone_len[v] < tvsg_pkg::SHORT_TONE)
                    lv = lv - 8'd1;
            end
            lvls[v] = lv[3:0];
        end
        r.level_a = lvls[0];
        r.level_b = lvls[1];
        r.level_c = lvls[2];
        r.port_a_value = chip_regs[tvsg_pkg::REG_PORT_A];
        r.port_b_value = chip_regs[tvsg_pkg::REG_PORT_B];
        return r;
    endfunction

    // small tone and envelope periods most of the time so the generators move
    function automatic logic [7:0] write_value(logic [7:0] r);
        logic [7:0] any;
        any = 8'($urandom);
        if (r >= REG_COUNT || $urandom_range(0, 3) == 0)
            return any;
        if (r < TONE_REGS)
            return r[0] ? 8'd0 : 8'($urandom_range(0, 8));
        if (r == tvsg_pkg::REG_ENV_LO)
            return 8'($urandom_range(0, 3));
        if (r == tvsg_pkg::REG_ENV_HI)
            return 8'd0;
        return any;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("ERROR: %s", msg);
    endtask

    task automatic check_field(string name, logic [7:0] got_v, logic [7:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("result %0d %s = %0h, expected %0h",
                                      results_checked, name, got_v, want_v));
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(tvsg_pkg::op_t op, logic [7:0] val, logic typed = 1'b0,
                             logic [7:0] typed_read = 8'h00);
        result_beat_t want;
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = sound_after_beat(op, val);
        if (typed)
            want.read_data = typed_read;
        expected_beats.push_back(want);
        beats_sent++;
        case (op)
            tvsg_pkg::OP_TICK:  ticks_sent++;
            tvsg_pkg::OP_WRITE: writes_sent++;
            tvsg_pkg::OP_READ:  reads_sent++;
            default: ;
        endcase
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(0, 99) >= 11);

    always @(posedge clk)
    begin
        result_beat_t got;
        result_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_beats.size() == 0)
                report_mismatch($sformatf("unexpected beat %h", m_tdata));
            else
            begin
                want = expected_beats.pop_front();
                check_field("read_data", got.read_data, want.read_data);
                check_field("level_a", 8'(got.level_a), 8'(want.level_a));
                check_field("level_b", 8'(got.level_b), 8'(want.level_b));
                check_field("level_c", 8'(got.level_c), 8'(want.level_c));
                check_field("port_a_value", got.port_a_value, want.port_a_value);
                check_field("port_a_changed", 8'(got.port_a_changed),
                            8'(want.port_a_changed));
                check_field("port_b_value", got.port_b_value, want.port_b_value);
                check_field("port_b_changed", 8'(got.port_b_changed),
                            8'(want.port_b_changed));
                check_field("pad", 8'(got.pad), 8'(want.pad));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_beats.size());
            $display("FAIL three_voice_sound_generator");
            $finish;
        end
    end

    initial
    begin
        int         pick;
        int         burst;
        logic [7:0] reg_pick;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = tvsg_pkg::OP_SELECT;

        foreach (chip_regs[i])
            chip_regs[i] = 8'h00;
        selected = 8'h00;
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            tone_len[v] = 12'd1;
            tone_ctr[v] = 12'd1;
            tone_hi[v]  = 1'b0;
        end
        noise_len = 5'd1;
        noise_ctr = 5'd1;
        lfsr      = 17'd1;
        env_per   = 16'd1;
        env_cnt   = 16'd1;
        env_sub   = 6'(ENV_STEPS);
        env_level = 8'h00;
        env_inc   = 8'h00;
        env_step  = 8'h00;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_beat(OPENING_SCRIPT[i].op, OPENING_SCRIPT[i].value,
                      OPENING_SCRIPT[i].typed, OPENING_SCRIPT[i].typed_read);

        // let the output side run dry before the random part
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (expected_beats.size() != 0)
            @(negedge clk);

        while (beats_sent < TOTAL_BEATS)
        begin
            steady = (beats_sent >= 600 && beats_sent < 900);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                reg_pick = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(16, 255))
                                                         : 8'($urandom_range(0, 15));
                send_beat(tvsg_pkg::OP_SELECT, reg_pick);
                send_beat(tvsg_pkg::OP_WRITE, write_value(reg_pick));
                if ($urandom_range(0, 2) == 0)
                    send_beat(tvsg_pkg::OP_READ, 8'($urandom));
            end
            else if (pick < 85)
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 30);
                if (burst > TOTAL_BEATS - beats_sent)
                    burst = TOTAL_BEATS - beats_sent;
                repeat (burst)
                    send_beat(tvsg_pkg::OP_TICK, 8'($urandom));
            end
            else
                send_beat(tvsg_pkg::op_t'($urandom_range(0, 3)), 8'($urandom));
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d beats: %0d ticks, %0d writes, %0d reads, rest selects",
                 beats_sent, ticks_sent, writes_sent, reads_sent);
        $display("checked %0d results field by field, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("PASS three_voice_sound_generator");
        else
            $display("FAIL three_voice_sound_generator");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tvsg_pkg.sv
sv/three_voice_sound_generator.sv
sim/three_voice_sound_generator_tb.sv
